FILE: rtl/atok_pkg.sv
// Package: types, character codes and helpers for the arithmetic expression tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package atok_pkg;

	localparam int POS_BITS = 16;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);

	localparam logic [3:0] KIND_END    = 4'd0;
	localparam logic [3:0] KIND_NUMBER = 4'd1;
	localparam logic [3:0] KIND_SYMBOL = 4'd2;
	localparam logic [3:0] KIND_PLUS   = 4'd3;
	localparam logic [3:0] KIND_MINUS  = 4'd4;
	localparam logic [3:0] KIND_STAR   = 4'd5;
	localparam logic [3:0] KIND_SLASH  = 4'd6;
	localparam logic [3:0] KIND_LPAREN = 4'd7;
	localparam logic [3:0] KIND_RPAREN = 4'd8;
	localparam logic [3:0] KIND_ERROR  = 4'd9;

	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	localparam logic signed [15:0] DEPTH_MAX = 16'sh7FFF;
	localparam logic signed [15:0] DEPTH_MIN = -16'sh8000;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_INT  = 2'd1,
		MODE_FRAC = 2'd2,
		MODE_SYM  = 2'd3
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_end;
	} src_word_t;

	typedef struct packed {
		logic [3:0]         kind;
		logic [15:0]        tok_start;
		logic [15:0]        tok_length;
		logic signed [15:0] paren_depth;
		logic [15:0]        last_open_pos;
		logic               last_of_run;
	} tok_word_t;

	function automatic logic num_char(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic letter_char(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
	endfunction

	// low 16 bits of a position, zero extended when positions are narrower
	function automatic logic [15:0] pos16(input logic [POS_BITS-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		return w[15:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/arithmetic_expression_tokenizer.sv
// A word waits in an input register, then its tokens go to a four-word result queue.
// One word per cycle while the queue has room; a word that closes a pending token and
// forms its own, or an end word closing one, gives two tokens; the single-word result
// port drains them one at a time, so the rate is set by it; the queue absorbs bursts.
// Reset: scanner idle at position zero, depth zero, queue empty.
`timescale 1ns / 1ps
`default_nettype none
module arithmetic_expression_tokenizer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                src_valid,
	output logic                     src_stall,
	input  wire atok_pkg::src_word_t src,
	output logic                     tok_valid,
	input  wire logic                tok_stall,
	output atok_pkg::tok_word_t      tok
);

	atok_pkg::src_word_t                     word_s1;
	logic                                    valid_s1;
	logic                                    fire;
	logic [1:0]                              cnt;
	atok_pkg::tok_word_t                     res0, res1;
	logic [atok_pkg::OQ_CNT_BITS-1:0]        free;

	assign fire      = valid_s1 && (atok_pkg::OQ_CNT_BITS'(cnt) <= free);
	assign src_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) word_s1 <= src;
	end

	atok_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.word   (word_s1),
		.res0   (res0),
		.res1   (res1),
		.cnt    (cnt)
	);

	atok_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (fire ? cnt : 2'd0),
		.d0     (res0),
		.d1     (res1),
		.pop    (tok_valid && !tok_stall),
		.valid  (tok_valid),
		.q      (tok),
		.free   (free)
	);

endmodule
`default_nettype wire

FILE: rtl/atok_core.sv
// Scanner state and single-pass token decode for one source word.
`timescale 1ns / 1ps
`default_nettype none
module atok_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire atok_pkg::src_word_t word,
	output atok_pkg::tok_word_t      res0,
	output atok_pkg::tok_word_t      res1,
	output logic [1:0]               cnt
);

	atok_pkg::scan_mode_t             mode_q, mode_d;
	logic [atok_pkg::POS_BITS-1:0]    pos_q, pos_d, pend_q, pend_d, open_q, open_d, pos_inc;
	logic signed [15:0]               depth_q, depth_d;
	logic                             dig, alp, dot, ext, has_pend;
	atok_pkg::tok_word_t              flush_w, end_w, one_w;
	logic [3:0]                       one_kind;

	always_comb begin
		dig      = atok_pkg::num_char(word.ch);
		alp      = atok_pkg::letter_char(word.ch);
		dot      = (word.ch == atok_pkg::CH_DOT);
		has_pend = (mode_q != atok_pkg::MODE_IDLE);
		ext      = ((mode_q == atok_pkg::MODE_INT) && (dig || dot)) ||
		           ((mode_q == atok_pkg::MODE_FRAC) && dig) ||
		           ((mode_q == atok_pkg::MODE_SYM) && (dig || alp));
		pos_inc  = (pos_q != atok_pkg::POS_MAX) ? pos_q + 1'b1 : pos_q;

		mode_d = mode_q;
		pos_d  = pos_q;
		pend_d = pend_q;
		depth_d = depth_q;
		open_d = open_q;
		cnt    = 2'd0;
		res0   = '0;
		res1   = '0;
		one_w  = '0;

		flush_w.kind          = (mode_q == atok_pkg::MODE_SYM) ?
		                        atok_pkg::KIND_SYMBOL : atok_pkg::KIND_NUMBER;
		flush_w.tok_start     = atok_pkg::pos16(pend_q);
		flush_w.tok_length    = atok_pkg::pos16(pos_q - pend_q);
		flush_w.paren_depth   = depth_q;
		flush_w.last_open_pos = atok_pkg::pos16(open_q);
		flush_w.last_of_run   = 1'b0;

		end_w             = flush_w;
		end_w.kind        = atok_pkg::KIND_END;
		end_w.tok_start   = atok_pkg::pos16(pos_q);
		end_w.tok_length  = 16'd0;

		one_kind = atok_pkg::KIND_ERROR;
		unique case (word.ch)
			atok_pkg::CH_PLUS:   one_kind = atok_pkg::KIND_PLUS;
			atok_pkg::CH_MINUS:  one_kind = atok_pkg::KIND_MINUS;
			atok_pkg::CH_STAR:   one_kind = atok_pkg::KIND_STAR;
			atok_pkg::CH_SLASH:  one_kind = atok_pkg::KIND_SLASH;
			atok_pkg::CH_LPAREN: one_kind = atok_pkg::KIND_LPAREN;
			atok_pkg::CH_RPAREN: one_kind = atok_pkg::KIND_RPAREN;
			default:             one_kind = atok_pkg::KIND_ERROR;
		endcase

		if (word.is_end) begin
			if (has_pend) begin
				res0 = flush_w;
				res1 = end_w;
				cnt  = 2'd2;
			end else begin
				res0 = end_w;
				cnt  = 2'd1;
			end
			mode_d = atok_pkg::MODE_IDLE;
			pos_d  = '0;
			pend_d = '0;
		end else if (ext) begin
			pos_d = pos_inc;
			if ((mode_q == atok_pkg::MODE_INT) && dot) begin
				mode_d = atok_pkg::MODE_FRAC;
			end
		end else begin
			mode_d = atok_pkg::MODE_IDLE;
			if (has_pend) begin
				res0 = flush_w;
				cnt  = 2'd1;
			end
			if (atok_pkg::is_space(word.ch)) begin
				pos_d = pos_inc;
			end else if (dig || alp) begin
				mode_d = dig ? atok_pkg::MODE_INT : atok_pkg::MODE_SYM;
				pend_d = pos_q;
				pos_d  = pos_inc;
			end else begin
				if (one_kind == atok_pkg::KIND_LPAREN) begin
					if (depth_q != atok_pkg::DEPTH_MAX) depth_d = depth_q + 16'sd1;
					open_d = pos_q;
				end else if (one_kind == atok_pkg::KIND_RPAREN) begin
					if (depth_q != atok_pkg::DEPTH_MIN) depth_d = depth_q - 16'sd1;
				end
				one_w               = flush_w;
				one_w.kind          = one_kind;
				one_w.tok_start     = atok_pkg::pos16(pos_q);
				one_w.tok_length    = 16'd1;
				one_w.paren_depth   = depth_d;
				one_w.last_open_pos = atok_pkg::pos16(open_d);
				if (has_pend) begin
					res1 = one_w;
					cnt  = 2'd2;
				end else begin
					res0 = one_w;
					cnt  = 2'd1;
				end
				pos_d = pos_inc;
			end
		end

		if (cnt == 2'd2) begin
			res1.last_of_run = 1'b1;
		end else if (cnt == 2'd1) begin
			res0.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= atok_pkg::MODE_IDLE;
			pos_q   <= '0;
			pend_q  <= '0;
			depth_q <= '0;
			open_q  <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			pend_q  <= pend_d;
			depth_q <= depth_d;
			open_q  <= open_d;
		end
	end

`ifndef NO_ASSERTIONS
	// end marker always yields at least the end token
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && word.is_end |-> (cnt != 2'd0) && (cnt == 2'd2 ? res1.kind : res0.kind)
			== atok_pkg::KIND_END)
		else $error("end marker without end token");
	// new source restarts at position zero in idle
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && word.is_end |=> (pos_q == '0) && (mode_q == atok_pkg::MODE_IDLE))
		else $error("scanner not restarted after end marker");
	// two tokens only when a pending token is closed
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && (cnt == 2'd2) |-> has_pend)
		else $error("two tokens without a pending token");
`endif

endmodule
`default_nettype wire

FILE: rtl/atok_outq.sv
// Result queue: takes up to two token words per cycle, delivers one.
`timescale 1ns / 1ps
`default_nettype none
module atok_outq (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [1:0]               push_n,
	input  wire atok_pkg::tok_word_t      d0,
	input  wire atok_pkg::tok_word_t      d1,
	input  wire logic                     pop,
	output logic                          valid,
	output atok_pkg::tok_word_t           q,
	output logic [atok_pkg::OQ_CNT_BITS-1:0] free
);

	atok_pkg::tok_word_t                   mem_q [atok_pkg::OQ_DEPTH];
	logic [atok_pkg::OQ_PTR_BITS-1:0]      wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [atok_pkg::OQ_CNT_BITS-1:0]      cnt_q;

	assign valid     = (cnt_q != '0);
	assign q         = mem_q[rd_ptr_q];
	assign free      = atok_pkg::OQ_CNT_BITS'(atok_pkg::OQ_DEPTH) - cnt_q;
	assign wr_ptr_nx = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_ptr_q] <= d0;
		if (push_n == 2'd2) mem_q[wr_ptr_nx] <= d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + atok_pkg::OQ_PTR_BITS'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + atok_pkg::OQ_CNT_BITS'(push_n)
			         - atok_pkg::OQ_CNT_BITS'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		atok_pkg::OQ_CNT_BITS'(push_n) <= free)
		else $error("result queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("pop from empty result queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= atok_pkg::OQ_CNT_BITS'(atok_pkg::OQ_DEPTH))
		else $error("result queue count out of range");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/arithmetic_expression_tokenizer_tb.sv
// Self-checking testbench for the arithmetic expression tokenizer with a scoreboard lexer.
`timescale 1ns / 1ps
module arithmetic_expression_tokenizer_tb;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_WORDS = 205;

	class tok_scoreboard;
		atok_pkg::scan_mode_t mode;
		logic [atok_pkg::POS_BITS-1:0] pos;
		logic [atok_pkg::POS_BITS-1:0] pend_start;
		logic [atok_pkg::POS_BITS-1:0] open_pos;
		logic signed [15:0] depth;
		atok_pkg::tok_word_t step_toks[$];
		atok_pkg::tok_word_t expected[$];
		int n_words;
		int n_tokens;
		int n_err;

		function new();
			mode = atok_pkg::MODE_IDLE;
			pos = '0;
			pend_start = '0;
			open_pos = '0;
			depth = '0;
			n_words = 0;
			n_tokens = 0;
			n_err = 0;
		endfunction

		function bit digit_ch(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit letter_ch(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		function bit blank_ch(logic [7:0] c);
			return c == atok_pkg::CH_SPACE || c == atok_pkg::CH_TAB || c == atok_pkg::CH_LF;
		endfunction

		function void bump_pos();
			if (pos != atok_pkg::POS_MAX) begin
				pos = pos + 1'b1;
			end
		endfunction

		function void emit(logic [3:0] k, logic [atok_pkg::POS_BITS-1:0] s,
				logic [atok_pkg::POS_BITS-1:0] len);
			atok_pkg::tok_word_t t;
			t.kind = k;
			t.tok_start = 16'(s);
			t.tok_length = 16'(len);
			t.paren_depth = depth;
			t.last_open_pos = 16'(open_pos);
			t.last_of_run = 1'b0;
			step_toks.push_back(t);
		endfunction

		function void close_pending();
			if (mode != atok_pkg::MODE_IDLE) begin
				emit(mode == atok_pkg::MODE_SYM ? atok_pkg::KIND_SYMBOL : atok_pkg::KIND_NUMBER,
					pend_start, pos - pend_start);
				mode = atok_pkg::MODE_IDLE;
			end
		endfunction

		// accepted source word -> expected tokens
		function void note_src(atok_pkg::src_word_t w);
			logic [3:0] k;
			atok_pkg::tok_word_t t;
			step_toks.delete();
			n_words++;
			if (w.is_end) begin
				close_pending();
				emit(atok_pkg::KIND_END, pos, '0);
				mode = atok_pkg::MODE_IDLE;
				pos = '0;
				pend_start = '0;
			end else if ((mode == atok_pkg::MODE_INT &&
					(digit_ch(w.ch) || w.ch == atok_pkg::CH_DOT)) ||
					(mode == atok_pkg::MODE_FRAC && digit_ch(w.ch)) ||
					(mode == atok_pkg::MODE_SYM && (digit_ch(w.ch) || letter_ch(w.ch)))) begin
				if (w.ch == atok_pkg::CH_DOT) begin
					mode = atok_pkg::MODE_FRAC;
				end
				bump_pos();
			end else begin
				close_pending();
				if (blank_ch(w.ch)) begin
					bump_pos();
				end else if (digit_ch(w.ch) || letter_ch(w.ch)) begin
					mode = digit_ch(w.ch) ? atok_pkg::MODE_INT : atok_pkg::MODE_SYM;
					pend_start = pos;
					bump_pos();
				end else begin
					case (w.ch)
						atok_pkg::CH_PLUS: k = atok_pkg::KIND_PLUS;
						atok_pkg::CH_MINUS: k = atok_pkg::KIND_MINUS;
						atok_pkg::CH_STAR: k = atok_pkg::KIND_STAR;
						atok_pkg::CH_SLASH: k = atok_pkg::KIND_SLASH;
						atok_pkg::CH_LPAREN: begin
							k = atok_pkg::KIND_LPAREN;
							if (depth != atok_pkg::DEPTH_MAX) begin
								depth = depth + 16'sd1;
							end
							open_pos = pos;
						end
						atok_pkg::CH_RPAREN: begin
							k = atok_pkg::KIND_RPAREN;
							if (depth != atok_pkg::DEPTH_MIN) begin
								depth = depth - 16'sd1;
							end
						end
						default: k = atok_pkg::KIND_ERROR;
					endcase
					emit(k, pos, atok_pkg::POS_BITS'(1));
					bump_pos();
				end
			end
			if (step_toks.size() != 0) begin
				t = step_toks.pop_back();
				t.last_of_run = 1'b1;
				step_toks.push_back(t);
			end
			foreach (step_toks[i]) begin
				expected.push_back(step_toks[i]);
			end
		endfunction

		function void field_ok(string name, logic signed [31:0] want, logic signed [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
				n_err++;
			end
		endfunction

		function void check_tok(atok_pkg::tok_word_t got);
			atok_pkg::tok_word_t want;
			n_tokens++;
			if (expected.size() == 0) begin
				$error("unexpected token: kind %0d start %0d", got.kind, got.tok_start);
				n_err++;
				return;
			end
			want = expected.pop_front();
			field_ok("kind", want.kind, got.kind);
			field_ok("tok_start", want.tok_start, got.tok_start);
			field_ok("tok_length", want.tok_length, got.tok_length);
			field_ok("paren_depth", want.paren_depth, got.paren_depth);
			field_ok("last_open_pos", want.last_open_pos, got.last_open_pos);
			field_ok("last_of_run", want.last_of_run, got.last_of_run);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	atok_pkg::src_word_t src = '0;
	logic tok_valid;
	logic tok_stall = 1'b0;
	atok_pkg::tok_word_t tok;

	int src_idle_pct = 34;
	int rcv_idle_pct = 62;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;
	int unsigned cycle_cnt = 0;
	tok_scoreboard sb = new();

	arithmetic_expression_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src(src),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok(tok)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d tokens outstanding", cycle_cnt,
				sb.expected.size());
			$display("** arithmetic_expression_tokenizer: FAILED **");
			$finish;
		end
	end

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_letter();
		return 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(0, 2))
			0: return atok_pkg::CH_SPACE;
			1: return atok_pkg::CH_TAB;
			default: return atok_pkg::CH_LF;
		endcase
	endfunction

	task automatic offer_word(input logic [7:0] c, input logic fin);
		atok_pkg::src_word_t w;
		w.ch = c;
		w.is_end = fin;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src <= w;
		src_valid <= 1'b1;
		do @(posedge clk); while (src_stall);
		sb.note_src(w);
	endtask

	// one lexeme of a mostly well-formed expression, with some noise
	task automatic send_lexeme();
		int pick;
		pick = $urandom_range(0, 39);
		if (pick < 12) begin
			repeat ($urandom_range(1, 4)) offer_word(rand_digit(), 1'b0);
			if ($urandom_range(0, 2) == 0) begin
				offer_word(atok_pkg::CH_DOT, 1'b0);
				repeat ($urandom_range(0, 3)) offer_word(rand_digit(), 1'b0);
				if ($urandom_range(0, 7) == 0) begin
					offer_word(atok_pkg::CH_DOT, 1'b0);
				end
			end
		end else if (pick < 20) begin
			offer_word(rand_letter(), 1'b0);
			repeat ($urandom_range(0, 4)) begin
				offer_word($urandom_range(0, 1) ? rand_letter() : rand_digit(), 1'b0);
			end
		end else if (pick < 28) begin
			case ($urandom_range(0, 3))
				0: offer_word(atok_pkg::CH_PLUS, 1'b0);
				1: offer_word(atok_pkg::CH_MINUS, 1'b0);
				2: offer_word(atok_pkg::CH_STAR, 1'b0);
				default: offer_word(atok_pkg::CH_SLASH, 1'b0);
			endcase
		end else if (pick < 33) begin
			offer_word(pick < 31 ? atok_pkg::CH_LPAREN : atok_pkg::CH_RPAREN, 1'b0);
		end else if (pick < 37) begin
			repeat ($urandom_range(1, 2)) offer_word(rand_blank(), 1'b0);
		end else if (pick < 39) begin
			offer_word(8'($urandom), 1'b0);
		end else begin
			offer_word(8'($urandom), 1'b1);
		end
	endtask

	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && tok_valid && !tok_stall) begin
				sb.check_tok(tok);
			end
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				tok_stall <= 1'b1;
			end else begin
				tok_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
			end
		end
	end

	initial begin : stimulus
		int target;
		logic [7:0] opening[23];
		opening = '{atok_pkg::CH_RPAREN, atok_pkg::CH_DOT, "0", atok_pkg::CH_DOT, "9",
			atok_pkg::CH_DOT, "Z", "a", "0", atok_pkg::CH_LPAREN, "A", "z",
			atok_pkg::CH_SPACE, atok_pkg::CH_TAB, "9", atok_pkg::CH_LF, atok_pkg::CH_PLUS,
			atok_pkg::CH_MINUS, atok_pkg::CH_STAR, atok_pkg::CH_SLASH, 8'h00, 8'hFF, "5"};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// unbalanced close, stray and second dots, class edges, all operators, odd bytes
		foreach (opening[i]) begin
			offer_word(opening[i], 1'b0);
		end
		offer_word(8'hFF, 1'b1);
		offer_word(8'h00, 1'b1);

		target = sb.n_words + PHASE_WORDS;
		while (sb.n_words < target) send_lexeme();
		src_idle_pct = 62;
		rcv_idle_pct = 34;
		target = sb.n_words + PHASE_WORDS;
		while (sb.n_words < target) send_lexeme();
		src_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_go = 1'b1;
		target = sb.n_words + PHASE_WORDS;
		while (sb.n_words < target) send_lexeme();
		offer_word(8'h00, 1'b1);

		@(negedge clk);
		src_valid <= 1'b0;
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.expected.size() != 0) begin
			$error("%0d expected tokens never arrived", sb.expected.size());
			sb.n_err++;
		end
		$display("Run covered %0d source words and %0d tokens under three pacing modes,",
			sb.n_words, sb.n_tokens);
		$display("with stray dots, class edges, odd bytes and a %0d-cycle result hold-off.",
			HOLD_CYCLES);
		if (sb.n_err == 0) begin
			$display("** arithmetic_expression_tokenizer: PASSED **");
		end else begin
			$display("** arithmetic_expression_tokenizer: FAILED **");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/atok_pkg.sv
rtl/atok_core.sv
rtl/atok_outq.sv
rtl/arithmetic_expression_tokenizer.sv
tb/sv/arithmetic_expression_tokenizer_tb.sv
